@@ design/fsd_pkg.sv @@
package fsd_pkg;

    localparam int PIXEL_W        = 8;
    localparam int LEVEL_BITS_W   = 4;
    localparam int IMAGE_WIDTH_W  = 12;
    localparam int IMAGE_HEIGHT_W = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int ERR_W          = 9;

    localparam int FSD_MAX_WIDTH   = 2048;
    localparam int FSD_QUEUE_DEPTH = 4;

    localparam logic [LEVEL_BITS_W-1:0]   LEVEL_BITS_RESET   = 4'd1;
    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

    // Diffusion weights, in sixteenths.
    localparam logic [3:0] WEIGHT_RIGHT       = 4'd7;
    localparam logic [3:0] WEIGHT_BELOW_LEFT  = 4'd3;
    localparam logic [3:0] WEIGHT_BELOW       = 4'd5;
    localparam logic [3:0] WEIGHT_BELOW_RIGHT = 4'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEVEL_BITS   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } fsd_cfg_index_t;

    typedef struct packed {
        logic first_row;
        logic last_col;
        logic last_row;
    } fsd_flags_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_SUM_ABOVE,
        BK_SUM_LEFT,
        BK_DIVIDE,
        BK_SCALE,
        BK_ROUND,
        BK_EMIT
    } fsd_back_state_t;

    // Quantiser constants per level count. The reciprocal is ceil(2^16 / (2*step)),
    // so that (2p + step) * recip >> 16 is the rounded quotient or one above it.
    typedef struct packed {
        logic [7:0]  step;
        logic [7:0]  top;
        logic [16:0] recip;
    } fsd_quant_t;

    function automatic fsd_quant_t fsd_quant_params(input logic [LEVEL_BITS_W-1:0] level_bits);
        fsd_quant_t qp;
        unique case (level_bits) inside
            4'd0, 4'd1:     qp = '{step: 8'd255, top: 8'd255, recip: 17'd129};
            4'd2:           qp = '{step: 8'd85,  top: 8'd255, recip: 17'd386};
            4'd3:           qp = '{step: 8'd36,  top: 8'd252, recip: 17'd911};
            4'd4:           qp = '{step: 8'd17,  top: 8'd255, recip: 17'd1928};
            4'd5:           qp = '{step: 8'd8,   top: 8'd248, recip: 17'd4096};
            4'd6:           qp = '{step: 8'd4,   top: 8'd252, recip: 17'd8192};
            4'd7:           qp = '{step: 8'd2,   top: 8'd254, recip: 17'd16384};
            [4'd8:4'd15]:   qp = '{step: 8'd1,   top: 8'd255, recip: 17'd32768};
        endcase
        return qp;
    endfunction

    // (err * weight) / 16, truncated toward zero.
    function automatic logic signed [ERR_W-1:0] fsd_spread(input logic signed [ERR_W-1:0] err,
                                                           input logic [3:0] weight);
        logic signed [13:0] prod;
        prod = err * $signed({1'b0, weight});
        if (prod < 0) begin
            prod = prod + 14'sd15;
        end
        return ERR_W'(prod >>> 4);
    endfunction

    function automatic logic [PIXEL_W-1:0] fsd_sat_add(input logic [PIXEL_W-1:0] pix,
                                                       input logic signed [ERR_W-1:0] delta);
        logic signed [10:0] sum;
        sum = $signed({3'b000, pix}) + 11'(delta);
        if (sum < 0) begin
            return 8'd0;
        end else if (sum > 11'sd255) begin
            return 8'd255;
        end else begin
            return sum[7:0];
        end
    endfunction

endpackage

@@ design/fsd_ram.sv @@
module fsd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/fsd_queue.sv @@
module fsd_queue #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push_ok, pop_ok;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/fsd_front.sv @@
module fsd_front
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = FSD_MAX_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [PIXEL_W-1:0]            s_tdata,      // [7:0] pixel_in
    input  logic [IMAGE_WIDTH_W-1:0]      image_width,
    input  logic [IMAGE_HEIGHT_W-1:0]     image_height,
    input  logic                          q_full,
    output logic                          push,
    output logic [PIXEL_W-1:0]            push_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]  push_x,
    output fsd_flags_t                    push_flags
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WCMP = (XW + 1 > IMAGE_WIDTH_W) ? XW + 1 : IMAGE_WIDTH_W;

    logic [XW-1:0]             x_reg, x_next;
    logic [IMAGE_HEIGHT_W-1:0] y_reg, y_next;
    logic [WCMP-1:0]           width_eff;
    logic [IMAGE_HEIGHT_W-1:0] height_eff;
    logic                      last_col, last_row;

    always_comb begin
        if (image_width == '0) begin
            width_eff = WCMP'(1);
        end else if (WCMP'(image_width) > WCMP'(MAX_WIDTH)) begin
            width_eff = WCMP'(MAX_WIDTH);
        end else begin
            width_eff = WCMP'(image_width);
        end
        height_eff = (image_height == '0) ? IMAGE_HEIGHT_W'(1) : image_height;
    end

    assign last_col = (WCMP'(x_reg) + WCMP'(1)) >= width_eff;
    assign last_row = ({1'b0, y_reg} + 17'd1) >= {1'b0, height_eff};

    assign s_tready   = !q_full;
    assign push       = s_tvalid && !q_full;
    assign push_pixel = s_tdata;
    assign push_x     = x_reg;
    assign push_flags = '{first_row: (y_reg == '0), last_col: last_col, last_row: last_row};

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (push) begin
            if (last_col) begin
                x_next = '0;
                y_next = last_row ? '0 : y_reg + IMAGE_HEIGHT_W'(1);
            end else begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
        end else begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

endmodule

@@ design/fsd_back.sv @@
module fsd_back
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = FSD_MAX_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [LEVEL_BITS_W-1:0]       level_bits,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [PIXEL_W-1:0]            q_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_x,
    input  fsd_flags_t                    q_flags,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [PIXEL_W-1:0]            m_tdata,
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser
);

    localparam int XW = $clog2(MAX_WIDTH);

    fsd_back_state_t state_reg, state_next;

    logic [PIXEL_W-1:0]      pix_reg;
    logic [XW-1:0]           x_reg;
    fsd_flags_t              flags_reg;
    logic signed [ERR_W-1:0] line0_reg;
    logic signed [ERR_W-1:0] a_reg, ar_reg;
    logic [PIXEL_W-1:0]      p_reg;
    logic [9:0]              num_reg;
    logic [8:0]              est_reg;
    logic [16:0]             prod_reg;
    logic [PIXEL_W-1:0]      q_reg;
    logic signed [ERR_W-1:0] left_reg, above_left_reg, above_reg;
    logic                    m_tvalid_reg;
    logic [PIXEL_W-1:0]      m_tdata_reg;
    logic                    m_tlast_reg;
    logic                    m_tuser_reg;

    logic                    ram_we;
    logic [XW-1:0]           ram_raddr;
    logic signed [ERR_W-1:0] ram_rdata;
    logic                    load_out;
    logic                    out_free;

    fsd_quant_t              qp;
    logic                    x_zero;
    logic signed [ERR_W-1:0] a_l, a_c, a_r;
    logic [PIXEL_W-1:0]      p_above;
    logic [9:0]              num;
    logic [26:0]             quot_prod;
    logic                    over;
    logic [16:0]             q_raw;
    logic signed [ERR_W-1:0] err;

    fsd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (x_reg),
        .wr_data (err),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign qp       = fsd_quant_params(level_bits);
    assign x_zero   = (x_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: one pixel at a time, one step per state.
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        ram_raddr  = '0;
        ram_we     = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                // Wraps past the last column; that read is discarded.
                ram_raddr  = x_reg + XW'(1);
                state_next = BK_SUM_ABOVE;
            end
            BK_SUM_ABOVE: state_next = BK_SUM_LEFT;
            BK_SUM_LEFT:  state_next = BK_DIVIDE;
            BK_DIVIDE:    state_next = BK_SCALE;
            BK_SCALE:     state_next = BK_ROUND;
            BK_ROUND:     state_next = BK_EMIT;
            BK_EMIT: begin
                if (out_free) begin
                    ram_we     = 1'b1;
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Terms from the row above, taken in the order below-right, below, below-left.
    always_comb begin
        a_l     = x_zero ? '0 : above_left_reg;
        a_c     = x_zero ? line0_reg : above_reg;
        a_r     = flags_reg.last_col ? '0 : ram_rdata;
        p_above = pix_reg;
        if (!flags_reg.first_row) begin
            if (!x_zero) begin
                p_above = fsd_sat_add(p_above, fsd_spread(a_l, WEIGHT_BELOW_RIGHT));
            end
            p_above = fsd_sat_add(p_above, fsd_spread(a_c, WEIGHT_BELOW));
            if (!flags_reg.last_col) begin
                p_above = fsd_sat_add(p_above, fsd_spread(a_r, WEIGHT_BELOW_LEFT));
            end
        end
    end

    assign num       = {1'b0, p_reg, 1'b0} + {2'b00, qp.step};
    assign quot_prod = num * qp.recip;
    assign over      = {prod_reg, 1'b0} > {8'd0, num_reg};
    assign q_raw     = over ? prod_reg - {9'd0, qp.step} : prod_reg;
    assign err       = $signed({1'b0, p_reg}) - $signed({1'b0, q_reg});

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pix_reg   <= q_pixel;
            x_reg     <= q_x;
            flags_reg <= q_flags;
        end
        if (state_reg == BK_READ) begin
            line0_reg <= ram_rdata;
        end
        if (state_reg == BK_SUM_ABOVE) begin
            p_reg  <= p_above;
            a_reg  <= a_c;
            ar_reg <= a_r;
        end
        if (state_reg == BK_SUM_LEFT && !x_zero) begin
            p_reg <= fsd_sat_add(p_reg, fsd_spread(left_reg, WEIGHT_RIGHT));
        end
        if (state_reg == BK_DIVIDE) begin
            num_reg <= num;
            est_reg <= quot_prod[24:16];
        end
        if (state_reg == BK_SCALE) begin
            prod_reg <= est_reg * qp.step;
        end
        if (state_reg == BK_ROUND) begin
            q_reg <= (q_raw >= {9'd0, qp.top}) ? 8'd255 : q_raw[7:0];
        end
        if (load_out) begin
            m_tdata_reg <= q_reg;
            m_tlast_reg <= flags_reg.last_col;
            m_tuser_reg <= flags_reg.last_col && flags_reg.last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            above_left_reg <= '0;
            above_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (load_out) begin
                left_reg       <= flags_reg.last_col ? '0 : err;
                above_left_reg <= flags_reg.last_col ? '0 : a_reg;
                above_reg      <= flags_reg.last_col ? '0 : ar_reg;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ design/floyd_steinberg_dither_gray_unit.sv @@
// Channel   Direction  Ports                        Contents
// s_        in         s_tvalid s_tready s_tdata    [7:0] pixel_in
// m_        out        m_tvalid m_tready m_tdata    [7:0] pixel_out
//                      m_tlast m_tuser              end_of_row, end_of_frame
// cfg_      in         cfg_we cfg_addr cfg_wdata    level_bits, image_width, image_height
//
// In the back end each pixel passes through a queue pop, two reads of the
// single-read-port line store, two summing steps, the reciprocal and scaling
// multiplies, rounding and the write-back. The front end counts positions and
// fills a four-entry queue, so input transfers continue while the back end works
// or a result waits on m_tready. Reset restores 2 levels and 640 x 480 and
// clears the counters and carried errors; the line store is not cleared.
module floyd_steinberg_dither_gray_unit
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH   = FSD_MAX_WIDTH,
    parameter int QUEUE_DEPTH = FSD_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,     // [7:0] pixel_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,     // [7:0] pixel_out
    output logic                  m_tlast,     // end_of_row
    output logic [0:0]            m_tuser,     // [0] end_of_frame
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int QW = XW + $bits(fsd_flags_t) + PIXEL_W;

    logic [LEVEL_BITS_W-1:0]   level_bits_reg;
    logic [IMAGE_WIDTH_W-1:0]  image_width_reg;
    logic [IMAGE_HEIGHT_W-1:0] image_height_reg;

    logic               push, pop, q_full, q_empty;
    logic [PIXEL_W-1:0] push_pixel;
    logic [XW-1:0]      push_x;
    fsd_flags_t         push_flags;
    logic [QW-1:0]      push_data, pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_bits_reg   <= LEVEL_BITS_RESET;
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LEVEL_BITS:   level_bits_reg   <= cfg_wdata[LEVEL_BITS_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[IMAGE_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[IMAGE_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    fsd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .push         (push),
        .push_pixel   (push_pixel),
        .push_x       (push_x),
        .push_flags   (push_flags)
    );

    assign push_data = {push_x, push_flags, push_pixel};

    fsd_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    fsd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .level_bits (level_bits_reg),
        .q_empty    (q_empty),
        .q_pop      (pop),
        .q_pixel    (pop_data[PIXEL_W-1:0]),
        .q_x        (pop_data[QW-1 -: XW]),
        .q_flags    (fsd_flags_t'(pop_data[PIXEL_W +: $bits(fsd_flags_t)])),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
